// File: sv/sacc_pkg.sv
// package for the set-associative cache controller
// holds geometry constants, transfer kind codes and register indexes
package sacc_pkg;

   localparam int LINES_DEF     = 256;
   localparam int ADDR_BITS_DEF = 16;

   localparam int KIND_W  = 3;
   localparam int COUNT_W = 9;
   localparam int CSR_W   = 9;
   localparam int CSR_IDX_W = 2;

   // transfer kinds
   localparam logic [KIND_W-1:0] KIND_TO_PROC   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FROM_PROC = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FILL      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_WRBACK    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DISCARD   = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SET_BITS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WAYS        = 2'd2;

endpackage

// File: sv/set_assoc_cache_controller_lru.sv
// Set-associative write-back write-allocate cache controller with LRU.
// Line state (valid, dirty, rank, tag) lives in one synchronous ram,
// one entry per line; the lookup walks the ways of a set one per cycle.
// Usage: pulse start with req_action/req_address while busy is low.
// Results come out on rsp_* with rsp_valid high for one cycle each:
// on a miss in a full set first the write-back or discard of the victim,
// on a miss the fill, and last the processor transfer (rsp_last high).
// The receiver cannot stall; results are never held back.
// A search pass reads one way of the set per cycle and an update pass
// reads and rewrites one way per cycle; the ram's single read and write
// port set this. After the request is taken, the search pass and then
// the update pass run, then one to three results go out, one per cycle,
// and the block returns to idle.
// Configuration writes over csr_* take effect at once and must only be
// made while busy is low.
// Reset: a clearing pass writes every line invalid, one per cycle;
// busy stays high during it.
module set_assoc_cache_controller_lru
   import sacc_pkg::*;
#(
   parameter int LINES     = LINES_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [ADDR_BITS-1:0] req_address,
   output logic                 rsp_valid,
   output logic [KIND_W-1:0]    rsp_transfer_kind,
   output logic [15:0]          rsp_start_address,
   output logic [COUNT_W-1:0]   rsp_word_count,
   output logic                 rsp_was_hit,
   output logic                 rsp_last,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int LW     = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int CW     = $clog2(LINES + 1);
   localparam int ENT_W  = 2 + 8 + ADDR_BITS;
   localparam int SHW    = $clog2(ADDR_BITS + 1);

   // states
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   logic [2:0] state_ff, state_in;

   // registers
   logic [3:0] off_ff, off_in;
   logic [3:0] setb_ff, setb_in;
   logic [8:0] ways_ff, ways_in;

   // effective geometry
   logic [3:0]    ob, sb;
   logic [CW-1:0] nw;
   always_comb begin
      logic [CW:0] cap;
      ob = (off_ff > 4'd8) ? 4'd8 : off_ff;
      if (ADDR_BITS < 8 && ob > 4'(ADDR_BITS)) ob = 4'(ADDR_BITS);
      sb = (setb_ff > 4'd8) ? 4'd8 : setb_ff;
      if ({2'b0, sb} > 6'(ADDR_BITS) - {2'b0, ob}) sb = 4'(6'(ADDR_BITS) - {2'b0, ob});
      if (sb > 4'(LW) || (LINES & (LINES - 1)) != 0 && sb >= 4'(LW))
         sb = ((LINES & (LINES - 1)) != 0) ? 4'(LW - 1) : 4'(LW);
      if (LINES == 1) sb = 4'd0;
      cap = (CW+1)'(LINES) >> sb;
      if (ways_ff == 9'd0) nw = CW'(1);
      else if ({{(CW+1){1'b0}}, ways_ff} > {9'd0, cap}) nw = CW'(cap);
      else nw = CW'(ways_ff);
      if (nw > CW'(256) && CW > 8) nw = CW'(256);
   end

   // tag shift, offset plus set bits
   logic [4:0] tsh;
   assign tsh = {1'b0, ob} + {1'b0, sb};

   // request registers
   logic                 wr_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [ADDR_BITS-1:0] tag_ff;
   logic [LW-1:0]        base_ff;
   logic [CW-1:0]        way_ff, way_in;

   // search results
   logic          hit_ff, hit_in;
   logic          free_ff, free_in;
   logic [CW-1:0] hway_ff, hway_in;
   logic [CW-1:0] fway_ff, fway_in;
   logic [CW-1:0] vway_ff, vway_in;
   logic [7:0]    best_ff, best_in;
   logic [ADDR_BITS-1:0] vtag_ff, vtag_in;
   logic          vdirty_ff, vdirty_in;
   logic [8:0]    oldr_ff, oldr_in;
   logic [1:0]    oidx_ff, oidx_in;

   // ram port
   logic                 ram_we;
   logic [LW-1:0]        ram_wa, ram_ra;
   logic [ENT_W-1:0]     ram_wd, ram_rd;

   sacc_ram #(.WIDTH(ENT_W), .DEPTH(LINES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   logic                 e_valid, e_dirty;
   logic [7:0]           e_rank;
   logic [ADDR_BITS-1:0] e_tag;
   assign {e_valid, e_dirty, e_rank, e_tag} = ram_rd;

   // chosen line and its way index of the read data in flight
   logic [CW-1:0] sel_way;
   logic [CW-1:0] rway;
   assign sel_way = hit_ff ? hway_ff : (free_ff ? fway_ff : vway_ff);
   assign rway    = way_ff - CW'(1);

   logic [ADDR_BITS-1:0] req_tag;
   logic [LW-1:0]        req_base;
   always_comb begin
      logic [ADDR_BITS-1:0] setidx;
      logic [2*LW+CW-1:0]   prod;
      req_tag  = req_address >> tsh;
      setidx   = (req_address >> ob) & ((ADDR_BITS'(1) << sb) - ADDR_BITS'(1));
      prod     = (2*LW+CW)'(setidx[LW-1:0]) * (2*LW+CW)'(nw);
      req_base = prod[LW-1:0];
   end

   assign busy = (state_ff != ST_IDLE);

   // main sequencer
   always_comb begin
      state_in  = state_ff;
      way_in    = way_ff;
      hit_in    = hit_ff;
      free_in   = free_ff;
      hway_in   = hway_ff;
      fway_in   = fway_ff;
      vway_in   = vway_ff;
      best_in   = best_ff;
      vtag_in   = vtag_ff;
      vdirty_in = vdirty_ff;
      oldr_in   = oldr_ff;
      oidx_in   = oidx_ff;
      ram_we    = 1'b0;
      ram_wa    = base_ff + LW'(rway);
      ram_wd    = ram_rd;
      ram_ra    = base_ff + LW'(way_ff);
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = LW'(way_ff);
            ram_wd = '0;
            way_in = way_ff + CW'(1);
            if (way_ff == CW'(LINES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            ram_ra = req_base;
            if (start) begin
               state_in = ST_SEARCH;
               way_in   = CW'(1);
               hit_in   = 1'b0;
               free_in  = 1'b0;
               best_in  = 8'd0;
               vway_in  = '0;
            end
         end
         ST_SEARCH: begin
            // one way of the set per cycle
            if (!hit_ff) begin
               if (e_valid && e_tag == tag_ff) begin
                  hit_in  = 1'b1;
                  hway_in = rway;
                  oldr_in = {1'b0, e_rank};
               end else if (!e_valid && !free_ff) begin
                  free_in = 1'b1;
                  fway_in = rway;
               end
               if (e_rank >= best_ff) begin
                  best_in   = e_rank;
                  vway_in   = rway;
                  vtag_in   = e_tag;
                  vdirty_in = e_dirty;
               end
            end
            way_in = way_ff + CW'(1);
            if (rway == nw - CW'(1)) begin
               state_in = ST_UPDATE;
               way_in   = CW'(1);
               ram_ra   = base_ff;
               if (!hit_in) oldr_in = free_in ? 9'd256 : {1'b0, best_in};
            end
         end
         ST_UPDATE: begin
            // rank aging and line rewrite, one way per cycle
            ram_we = 1'b1;
            if (rway == sel_way) begin
               ram_wd = {1'b1, hit_ff ? (e_dirty | wr_ff) : wr_ff, 8'd0,
                         hit_ff ? e_tag : tag_ff};
            end else if (e_valid && {1'b0, e_rank} < oldr_ff && e_rank != 8'd255) begin
               ram_wd = {e_valid, e_dirty, e_rank + 8'd1, e_tag};
            end
            way_in = way_ff + CW'(1);
            if (rway == nw - CW'(1)) begin
               state_in = ST_OUT;
               oidx_in  = (hit_ff || free_ff) ? 2'd1 : 2'd0;
               if (hit_ff) oidx_in = 2'd2;
            end
         end
         ST_OUT: begin
            oidx_in = oidx_ff + 2'd1;
            if (oidx_ff == 2'd2) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // results
   logic [ADDR_BITS-1:0] bmask;
   assign bmask = ~((ADDR_BITS'(1) << ob) - ADDR_BITS'(1));
   always_comb begin
      logic [ADDR_BITS-1:0] vaddr, setpart;
      setpart = (addr_ff >> ob) & ((ADDR_BITS'(1) << sb) - ADDR_BITS'(1));
      vaddr   = (vtag_ff << tsh) | (setpart << ob);
      rsp_valid         = (state_ff == ST_OUT);
      rsp_was_hit       = hit_ff;
      rsp_last          = (oidx_ff == 2'd2);
      rsp_word_count    = COUNT_W'(9'd1 << ob);
      rsp_start_address = 16'(addr_ff & bmask);
      case (oidx_ff)
         2'd0: begin
            rsp_transfer_kind = vdirty_ff ? KIND_WRBACK : KIND_DISCARD;
            rsp_start_address = 16'(vaddr);
         end
         2'd1: rsp_transfer_kind = KIND_FILL;
         default: begin
            rsp_transfer_kind = wr_ff ? KIND_FROM_PROC : KIND_TO_PROC;
            rsp_start_address = 16'(addr_ff);
            rsp_word_count    = COUNT_W'(1);
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         way_ff   <= '0;
         off_ff   <= 4'd0;
         setb_ff  <= 4'd0;
         ways_ff  <= 9'd1;
         oidx_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         way_ff   <= way_in;
         off_ff   <= off_in;
         setb_ff  <= setb_in;
         ways_ff  <= ways_in;
         oidx_ff  <= oidx_in;
      end
   end

   // configuration writes
   always_comb begin
      off_in  = off_ff;
      setb_in = setb_ff;
      ways_in = ways_ff;
      if (csr_write) begin
         case (csr_index)
            REG_OFFSET_BITS: off_in  = csr_data[3:0];
            REG_SET_BITS:    setb_in = csr_data[3:0];
            REG_WAYS:        ways_in = csr_data;
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hit_ff    <= hit_in;
      free_ff   <= free_in;
      hway_ff   <= hway_in;
      fway_ff   <= fway_in;
      vway_ff   <= vway_in;
      best_ff   <= best_in;
      vtag_ff   <= vtag_in;
      vdirty_ff <= vdirty_in;
      oldr_ff   <= oldr_in;
      if (state_ff == ST_IDLE && start) begin
         wr_ff   <= req_action;
         addr_ff <= req_address;
         tag_ff  <= req_tag;
         base_ff <= req_base;
      end
   end

`ifndef ASSERT_OFF
   // the last result of a request is always the processor transfer
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_transfer_kind == KIND_TO_PROC ||
                                rsp_transfer_kind == KIND_FROM_PROC)
      else $error("last result is not a processor transfer");
   // a hit gives a single result
   a_hit_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_hit |-> rsp_last)
      else $error("hit produced more than one result");
   // after the final result the block is free again
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy)
      else $error("block still busy after last result");
   // no results outside the output phase of a request
   a_no_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_valid)
      else $error("result while idle");
`endif

endmodule

// File: sv/sacc_ram.sv
// generic single-port-write, single-read synchronous ram
// registered read data, no dependencies
module sacc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: tb/tb.sv
// testbench for the set-associative cache controller with lru replacement
// depends on sacc_pkg and set_assoc_cache_controller_lru; self-checking
module tb;
   import sacc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NLINES = 256;

   typedef struct packed {
      logic        wr;
      logic [15:0] addr;
   } access_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [15:0]        start;
      logic [COUNT_W-1:0] count;
      logic               hit;
      logic               fin;
   } transfer_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_action = 1'b0;
   logic [15:0]          req_address = '0;
   logic                 rsp_valid;
   logic [KIND_W-1:0]    rsp_transfer_kind;
   logic [15:0]          rsp_start_address;
   logic [COUNT_W-1:0]   rsp_word_count;
   logic                 rsp_was_hit;
   logic                 rsp_last;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_OFFSET_BITS;
   logic [CSR_W-1:0]     csr_data = '0;

   set_assoc_cache_controller_lru dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic        lv [NLINES];
   logic        ld [NLINES];
   logic [15:0] lt [NLINES];
   logic [7:0]  lr [NLINES];
   logic [3:0]  cfg_off;
   logic [3:0]  cfg_set;
   logic [8:0]  cfg_ways;

   access_type   pending_q[$];
   transfer_type expected_q[$];
   int        errors = 0;
   int        n_results = 0;
   int        n_hits = 0;
   int        n_evicts = 0;
   int        idle_pct = 0;
   bit        driving_done = 0;

   task automatic report(input string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   // promote line h to most recent within its set
   function automatic void promote(int base, int nw, int h);
      int old;
      old = lv[h] ? lr[h] : 256;
      for (int w = 0; w < nw; w++)
         if (base + w != h && lv[base+w] && lr[base+w] < old && lr[base+w] < 255)
            lr[base+w]++;
      lr[h] = 0;
   endfunction

   // compute the transfers one access causes and update line state
   function automatic void predict_access(input access_type a);
      int ob, sb, nw, cap, bs, set, base, h, best;
      logic [15:0] tag, blk, vaddr;
      bit hit, found;
      ob = cfg_off > 8 ? 8 : cfg_off;
      sb = cfg_set > 8 ? 8 : cfg_set;
      if (sb > 16 - ob) sb = 16 - ob;
      nw = cfg_ways == 0 ? 1 : cfg_ways;
      if (nw > 256) nw = 256;
      cap = NLINES >> sb;
      if (nw > cap) nw = cap;
      bs = 1 << ob;
      set = (a.addr >> ob) & ((1 << sb) - 1);
      tag = a.addr >> (ob + sb);
      blk = 16'(a.addr & ~(bs - 1));
      base = set * nw;
      h = base;
      hit = 0;
      for (int w = 0; w < nw; w++)
         if (!hit && lv[base+w] && lt[base+w] == tag) begin
            hit = 1;
            h = base + w;
         end
      if (!hit) begin
         found = 0;
         for (int w = 0; w < nw; w++)
            if (!found && !lv[base+w]) begin
               found = 1;
               h = base + w;
            end
         if (!found) begin
            // victim: highest rank, ties go to the higher way
            best = 0;
            h = base;
            for (int w = 0; w < nw; w++)
               if (lr[base+w] >= best) begin
                  best = lr[base+w];
                  h = base + w;
               end
            vaddr = 16'((32'(lt[h]) << (ob + sb)) | (32'(set) << ob));
            expected_q.push_back('{ld[h] ? KIND_WRBACK : KIND_DISCARD, vaddr,
                                   COUNT_W'(bs), 1'b0, 1'b0});
            n_evicts++;
         end
         expected_q.push_back('{KIND_FILL, blk, COUNT_W'(bs), 1'b0, 1'b0});
         promote(base, nw, h);
         lv[h] = 1;
         lt[h] = tag;
         ld[h] = 0;
      end else begin
         promote(base, nw, h);
         n_hits++;
      end
      if (a.wr) ld[h] = 1;
      expected_q.push_back('{a.wr ? KIND_FROM_PROC : KIND_TO_PROC, a.addr,
                             COUNT_W'(1), hit, 1'b1});
   endfunction

   // driver: requests change at the falling edge
   always @(negedge clock) begin
      if (!reset && !driving_done && pending_q.size() > 0
          && $urandom_range(99) >= idle_pct) begin
         start <= 1'b1;
         req_action <= pending_q[0].wr;
         req_address <= pending_q[0].addr;
      end else begin
         start <= 1'b0;
      end
   end

   // acceptance and monitor at the rising edge
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         predict_access(pending_q.pop_front());
      end
      if (!reset && rsp_valid) begin
         n_results++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected transfer kind %0d addr %h",
                             rsp_transfer_kind, rsp_start_address));
         end else begin
            transfer_type e;
            e = expected_q.pop_front();
            if (rsp_transfer_kind !== e.kind)
               report($sformatf("kind %0d, want %0d", rsp_transfer_kind, e.kind));
            if (rsp_start_address !== e.start)
               report($sformatf("address %h, want %h", rsp_start_address, e.start));
            if (rsp_word_count !== e.count)
               report($sformatf("count %0d, want %0d", rsp_word_count, e.count));
            if (rsp_was_hit !== e.hit)
               report($sformatf("hit %0b, want %0b", rsp_was_hit, e.hit));
            if (rsp_last !== e.fin)
               report($sformatf("last %0b, want %0b", rsp_last, e.fin));
         end
      end
   end

   // wait for all queued requests to go in and all transfers to come out
   task automatic drain();
      while (pending_q.size() > 0 || start) @(posedge clock);
      while (expected_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_W'(val);
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_OFFSET_BITS: cfg_off = val[3:0];
         REG_SET_BITS:    cfg_set = val[3:0];
         default:         cfg_ways = val[8:0];
      endcase
   endtask

   task automatic push(input int wr, input logic [15:0] addr);
      pending_q.push_back('{wr[0], addr});
   endtask

   // random phase: mostly addresses drawn from a small tag pool to get hits
   task automatic random_phase(input int count, input int idle);
      logic [15:0] pool[8];
      idle_pct = idle;
      foreach (pool[i]) pool[i] = 16'($urandom);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            push($urandom_range(1), 16'($urandom));
         else
            push($urandom_range(1), pool[$urandom_range(7)] ^ 16'($urandom_range(3)));
      end
      drain();
   endtask

   // stimulus
   initial begin
      for (int i = 0; i < NLINES; i++) begin
         lv[i] = 0; ld[i] = 0; lt[i] = 0; lr[i] = 0;
      end
      cfg_off = 0; cfg_set = 0; cfg_ways = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset geometry, extremes of address, hits, evictions
      push(0, 16'h0000); push(1, 16'h0000); push(0, 16'hFFFF);
      push(1, 16'hFFFF); push(0, 16'h0000); push(0, 16'hAAAA);
      drain();
      // oversized offset and set fields, zero ways
      csr_put(REG_OFFSET_BITS, 15); csr_put(REG_SET_BITS, 15);
      csr_put(REG_WAYS, 0);
      push(1, 16'h1234); push(0, 16'h1235); push(0, 16'h5555);
      drain();
      // too many ways, full associativity with tiny blocks
      csr_put(REG_OFFSET_BITS, 0); csr_put(REG_SET_BITS, 0);
      csr_put(REG_WAYS, 511);
      push(0, 16'h0001); push(1, 16'h0002); push(0, 16'h0001);
      drain();
      // two ways in one set: lru victim and dirty write-back
      csr_put(REG_WAYS, 2); csr_put(REG_SET_BITS, 7); csr_put(REG_OFFSET_BITS, 2);
      push(1, 16'h0000); push(0, 16'h4000); push(0, 16'h0000);
      push(0, 16'h8000); push(1, 16'hC003); push(0, 16'h4000);
      push(0, 16'h0003);
      drain();

      // random phases over several geometries and idling mixes
      csr_put(REG_OFFSET_BITS, 1); csr_put(REG_SET_BITS, 2); csr_put(REG_WAYS, 4);
      random_phase(90, 0);
      csr_put(REG_OFFSET_BITS, 8); csr_put(REG_SET_BITS, 8); csr_put(REG_WAYS, 256);
      random_phase(60, 47);
      csr_put(REG_OFFSET_BITS, 0); csr_put(REG_SET_BITS, 0); csr_put(REG_WAYS, 256);
      random_phase(60, 27);
      csr_put(REG_OFFSET_BITS, 3); csr_put(REG_SET_BITS, 4); csr_put(REG_WAYS, 3);
      random_phase(90, 47);
      csr_put(REG_OFFSET_BITS, 9); csr_put(REG_SET_BITS, 9); csr_put(REG_WAYS, 1);
      random_phase(60, 0);
      csr_put(REG_OFFSET_BITS, 2); csr_put(REG_SET_BITS, 6); csr_put(REG_WAYS, 2);
      random_phase(70, 27);
      driving_done = 1;

      repeat (30) @(posedge clock);
      $display("covered %0d transfers, %0d hits, %0d evictions over ten geometries",
               n_results, n_hits, n_evicts);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("set_assoc_cache_controller_lru verification clean");
      end else begin
         $display("%0d mismatches, %0d transfers still owed", errors, expected_q.size());
         $display("set_assoc_cache_controller_lru verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("timeout");
      $display("set_assoc_cache_controller_lru verification failed");
      $finish;
   end
endmodule
